[rtl/evq_pkg.sv]
// ----------------------------------------------------------------------------
// evq_pkg
// Shared types and codes of the event queue with flight recorder.
// ----------------------------------------------------------------------------
package evq_pkg;

  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 6;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Operation codes carried in the input tuser
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;

  // Record type carried in the output tuser
  localparam logic REC_EVENT  = 1'b0;
  localparam logic REC_HEADER = 1'b1;

  // One stored trace entry, 50 bits
  typedef struct packed {
    logic [7:0]  chan;
    logic [7:0]  code;
    logic [1:0]  kind;
    logic [31:0] ts;
  } evq_entry_t;

  localparam int ENTRY_W = $bits(evq_entry_t);

endpackage

[rtl/evq_ram.sv]
// ----------------------------------------------------------------------------
// evq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module evq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // rdata holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/event_queue_with_flight_recorder_core.sv]
// ----------------------------------------------------------------------------
// event_queue_with_flight_recorder_core
// Event trace unit: drop-newest transmit FIFO plus circular history ring.
//
//   channel | dir | payload                                   | transfer when
//   --------+-----+-------------------------------------------+------------------
//   s_*     | in  | tuser mode, tdata kind/type/channel/ts    | s_tvalid&s_tready
//   m_*     | out | tuser record type, tdata event or count   | m_tvalid&m_tready
//   cfg_*   | in  | cfg_data = event_enable                   | cfg_valid&cfg_ready
//
// Flow: a push, a mode-3 item, an empty poll or a disabled poll is handled in
// ST_IDLE alone. An enabled poll sends N entries from ST_EMIT, a replay a header
// from ST_HDR and then N history entries from ST_EMIT; results leave at one per
// cycle while m_tready is high, paced by the registered read of the queue and
// history RAMs (read issued while the previous result moves into the output register).
// Reset: synchronous, clears pointers, counts and event_enable (to 1); the RAM
// contents are not cleared and are only read where written.
// Stalls: m_tready low holds the output register and the walk; a new item is
// taken as soon as the last result of the previous one sits in the output
// register.
// ----------------------------------------------------------------------------
module event_queue_with_flight_recorder_core #(
  parameter int QUEUE_DEPTH    = 64,
  parameter int LOG_DEPTH      = 32,
  parameter int DRAIN_PER_POLL = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: [1:0] event_kind, [9:2] event_type, [17:10] channel,
  //          [49:18] timestamp, [55:50] zero
  // s_tuser: [1:0] mode
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [evq_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [evq_pkg::MODE_W-1:0]      s_tuser,
  // m_tdata: [31:0] out_timestamp, [33:32] out_kind, [41:34] out_type,
  //          [49:42] out_channel, [55:50] history_count
  // m_tuser: [0] record_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [evq_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [0:0]                      m_tuser,
  output logic                            m_tlast,
  // event_enable write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_data
);

  import evq_pkg::*;

  localparam int QA   = $clog2(QUEUE_DEPTH);
  localparam int OW   = $clog2(QUEUE_DEPTH + 1);
  localparam int HA   = $clog2(LOG_DEPTH);
  localparam int HCW  = $clog2(LOG_DEPTH + 1);
  localparam int MAXR = (LOG_DEPTH > DRAIN_PER_POLL) ? LOG_DEPTH : DRAIN_PER_POLL;
  localparam int RW   = $clog2(MAXR + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  // Queue pointers: index plus lap bit (full when indexes match, laps differ)
  logic [QA-1:0]  head_idx, tail_idx;
  logic           head_lap, tail_lap;
  // History ring
  logic [HA-1:0]  h_wr, h_rd;
  logic [HCW-1:0] h_cnt;
  logic           event_enable;
  // Walk control
  logic [RW-1:0]  rem;
  logic           src_hist;
  // Output register
  evq_entry_t     out_entry;
  logic [COUNT_W-1:0] out_count;

  evq_entry_t in_entry;
  logic [MODE_W-1:0] in_mode;
  logic s_acc, out_load_ok, out_load;

  logic [OW-1:0]  q_occ;
  logic           q_full;
  logic [RW-1:0]  npop;
  logic [QA-1:0]  head_inc, tail_inc, head_adv;
  logic           head_inc_lap, tail_inc_lap, head_adv_lap;
  logic [QA:0]    head_sum;
  logic [HA-1:0]  h_wr_inc, h_rd_inc, h_oldest;
  logic [HCW:0]   h_tmp;

  logic q_we, q_re, h_we, h_re;
  evq_entry_t q_rdata, h_rdata;

  assign in_entry = '{ts: s_tdata[49:18], chan: s_tdata[17:10],
                      code: s_tdata[9:2], kind: s_tdata[1:0]};
  assign in_mode  = s_tuser;

  assign s_tready    = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign s_acc       = s_tvalid && s_tready;
  assign out_load_ok = !m_tvalid || m_tready;
  // a header or an event record moves into the output register this cycle
  assign out_load    = out_load_ok && ((state == ST_HDR) || (state == ST_EMIT));

  // Queue occupancy and pops per poll
  always_comb begin
    if (head_lap == tail_lap) begin
      q_occ = OW'(tail_idx) - OW'(head_idx);
    end else begin
      q_occ = OW'(QUEUE_DEPTH) + OW'(tail_idx) - OW'(head_idx);
    end
    q_full = (head_idx == tail_idx) && (head_lap != tail_lap);
    if (32'(q_occ) < DRAIN_PER_POLL) begin
      npop = RW'(q_occ);
    end else begin
      npop = RW'(DRAIN_PER_POLL);
    end
  end

  // Pointer steps with wrap at non power-of-two depths
  always_comb begin
    if (head_idx == QA'(QUEUE_DEPTH - 1)) begin
      head_inc     = '0;
      head_inc_lap = !head_lap;
    end else begin
      head_inc     = head_idx + QA'(1);
      head_inc_lap = head_lap;
    end
    if (tail_idx == QA'(QUEUE_DEPTH - 1)) begin
      tail_inc     = '0;
      tail_inc_lap = !tail_lap;
    end else begin
      tail_inc     = tail_idx + QA'(1);
      tail_inc_lap = tail_lap;
    end
    // bulk pop while disabled: npop never exceeds occupancy
    head_sum = (QA+1)'(head_idx) + (QA+1)'(npop);
    if (head_sum >= (QA+1)'(QUEUE_DEPTH)) begin
      head_adv     = QA'(head_sum - (QA+1)'(QUEUE_DEPTH));
      head_adv_lap = !head_lap;
    end else begin
      head_adv     = QA'(head_sum);
      head_adv_lap = head_lap;
    end
    h_wr_inc = (h_wr == HA'(LOG_DEPTH - 1)) ? '0 : h_wr + HA'(1);
    h_rd_inc = (h_rd == HA'(LOG_DEPTH - 1)) ? '0 : h_rd + HA'(1);
    // oldest valid history slot
    if ((HCW+1)'(h_wr) >= (HCW+1)'(h_cnt)) begin
      h_tmp = (HCW+1)'(h_wr) - (HCW+1)'(h_cnt);
    end else begin
      h_tmp = (HCW+1)'(h_wr) + (HCW+1)'(LOG_DEPTH) - (HCW+1)'(h_cnt);
    end
    h_oldest = HA'(h_tmp);
  end

  // RAM port control
  assign q_we = s_acc && (in_mode == MODE_PUSH) && !q_full;
  assign h_we = s_acc && (in_mode == MODE_PUSH);
  assign q_re = (s_acc && (in_mode == MODE_POLL) && (npop != '0) && event_enable)
             || ((state == ST_EMIT) && !src_hist && out_load_ok && (rem != RW'(1)));
  assign h_re = ((state == ST_HDR) && out_load_ok && (h_cnt != '0))
             || ((state == ST_EMIT) && src_hist && out_load_ok && (rem != RW'(1)));

  evq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_idx),
    .wdata (in_entry),
    .re    (q_re),
    .raddr (head_idx),
    .rdata (q_rdata)
  );

  evq_ram #(.DEPTH(LOG_DEPTH), .WIDTH(ENTRY_W)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_wr),
    .wdata (in_entry),
    .re    (h_re),
    .raddr (h_rd),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head_idx     <= '0;
      head_lap     <= 1'b0;
      tail_idx     <= '0;
      tail_lap     <= 1'b0;
      h_wr         <= '0;
      h_rd         <= '0;
      h_cnt        <= '0;
      event_enable <= 1'b1;
      rem          <= '0;
      src_hist     <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
      m_tuser      <= REC_EVENT;
    end else begin
      if (cfg_valid) begin
        event_enable <= cfg_data[0];
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (in_mode)
              MODE_PUSH: begin
                h_wr <= h_wr_inc;
                if (h_cnt != HCW'(LOG_DEPTH)) begin
                  h_cnt <= h_cnt + HCW'(1);
                end
                if (!q_full) begin
                  tail_idx <= tail_inc;
                  tail_lap <= tail_inc_lap;
                end
              end
              MODE_POLL: begin
                if (npop != '0) begin
                  if (event_enable) begin
                    // first read issued now, head pops as each read goes out
                    head_idx <= head_inc;
                    head_lap <= head_inc_lap;
                    rem      <= npop;
                    src_hist <= 1'b0;
                    state    <= ST_EMIT;
                  end else begin
                    head_idx <= head_adv;
                    head_lap <= head_adv_lap;
                  end
                end
              end
              MODE_REPLAY: begin
                h_rd     <= h_oldest;
                rem      <= RW'(h_cnt);
                src_hist <= 1'b1;
                state    <= ST_HDR;
              end
              default: begin
              end
            endcase
          end
        end
        ST_HDR: begin
          if (out_load_ok) begin
            m_tuser   <= REC_HEADER;
            m_tlast   <= (h_cnt == '0);
            out_entry <= '0;
            out_count <= COUNT_W'(h_cnt);
            if (h_cnt != '0) begin
              h_rd  <= h_rd_inc;
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_load_ok) begin
            m_tuser   <= REC_EVENT;
            m_tlast   <= (rem == RW'(1));
            out_entry <= src_hist ? h_rdata : q_rdata;
            out_count <= '0;
            rem       <= rem - RW'(1);
            if (rem == RW'(1)) begin
              state <= ST_IDLE;
            end else if (src_hist) begin
              h_rd <= h_rd_inc;
            end else begin
              head_idx <= head_inc;
              head_lap <= head_inc_lap;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {out_count, out_entry.chan, out_entry.code, out_entry.kind, out_entry.ts};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_occ: assert property (@(posedge clk) disable iff (rst)
    32'(q_occ) <= QUEUE_DEPTH)
    else $error("queue occupancy beyond depth");

  a_hist_cnt: assert property (@(posedge clk) disable iff (rst)
    32'(h_cnt) <= LOG_DEPTH)
    else $error("history count beyond depth");

  a_walk_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem != '0))
    else $error("walk running with nothing left");

  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == REC_HEADER) && m_tlast) |-> (out_count == '0))
    else $error("header marked last with entries to follow");

endmodule
